FILE: hw/rtl/whs_pkg.sv
// ----------------------------------------------------------------------------
// whs_pkg
// shared types and constants of the wheel torque headroom scaler
// ----------------------------------------------------------------------------
package whs_pkg;

  localparam int CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIRE_RADIUS        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GEAR_RATIO         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CURRENT_PER_TORQUE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PHASE_RESISTANCE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EMF_COEFF          = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SLIP_VOLTAGE   = 3'd5;

  localparam logic [31:0] CFG_RESET = 32'h0001_0000;
  localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] tire_radius;
    logic [31:0] gear_ratio;
    logic [31:0] current_per_torque;
    logic [31:0] phase_resistance;
    logic [31:0] emf_coeff;
    logic [31:0] max_slip_voltage;
  } cfg_t;

  // one request after sign/magnitude split
  typedef struct packed {
    logic [3:0][31:0] fmag;
    logic [3:0]       fneg;
    logic [3:0][47:0] smag;
    logic [3:0]       sneg;
    logic [31:0]      supply;
  } item_t;

endpackage

FILE: hw/rtl/whs_front.sv
// ----------------------------------------------------------------------------
// whs_front
// takes requests, splits signed fields into sign and magnitude, two-entry queue
// ----------------------------------------------------------------------------
module whs_front
  import whs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] force_0,
  input  logic signed [31:0] force_1,
  input  logic signed [31:0] force_2,
  input  logic signed [31:0] force_3,
  input  logic signed [47:0] motor_speed_0,
  input  logic signed [47:0] motor_speed_1,
  input  logic signed [47:0] motor_speed_2,
  input  logic signed [47:0] motor_speed_3,
  input  logic        [31:0] supply_voltage,
  output logic               q_valid,
  output item_t              q_data,
  input  logic               q_pop
);

  item_t       mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  item_t       entry;
  logic        push;

  logic [3:0][31:0] fr;
  logic [3:0][47:0] sp;

  assign fr = {force_3, force_2, force_1, force_0};
  assign sp = {motor_speed_3, motor_speed_2, motor_speed_1, motor_speed_0};

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      entry.fneg[w] = fr[w][31];
      entry.fmag[w] = fr[w][31] ? (~fr[w] + 32'd1) : fr[w];
      entry.sneg[w] = sp[w][47];
      entry.smag[w] = sp[w][47] ? (~sp[w] + 48'd1) : sp[w];
    end
    entry.supply = supply_voltage;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: hw/rtl/whs_div.sv
// ----------------------------------------------------------------------------
// whs_div
// restoring divider, one quotient bit a cycle, saturating 32-bit quotient
// ----------------------------------------------------------------------------
module whs_div
  import whs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nsh;
  logic [NW-1:0] q;
  logic [63:0]   rem;
  logic [63:0]   dsor;
  logic [CW-1:0] cnt;
  logic [64:0]   trial;

  assign trial = {rem, nsh[NW-1]};
  // zero divisor leaves all ones in q, which saturates as required
  assign quot  = (|q[NW-1:32]) ? SAT32 : q[31:0];

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= {num, {FRAC_BITS{1'b0}}};
      dsor <= den;
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dsor}) begin
        rem <= 64'(trial - {1'b0, dsor});
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial[63:0];
        q   <= {q[NW-2:0], 1'b0};
      end
      nsh <= {nsh[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/whs_back.sv
// ----------------------------------------------------------------------------
// whs_back
// per-wheel sequencer: shared multiplier, shared divider, output register
// ----------------------------------------------------------------------------
module whs_back
  import whs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] scale_factor,
  output logic        slip_limited
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_MUL_SUM, S_APP, S_SLIP_DIV, S_RATIO_DIV, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ST_RADIUS, ST_GEAR, ST_CURRENT, ST_RESIST, ST_EMF
  } step_t;

  state_t      state;
  step_t       step;
  item_t       item;
  logic [1:0]  wheel;
  logic [63:0] acc;
  logic [63:0] rmag;
  logic [63:0] vmax;
  logic [31:0] slip_min;
  logic [31:0] emf_ratio;
  logic [63:0] prod_lo;
  logic [63:0] prod_hi;
  logic [31:0] mul_b;
  logic [95:0] full;
  logic [63:0] qres;
  logic [63:0] app;
  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_num;
  logic [63:0] div_den;
  logic [31:0] div_quot;

  always_comb begin
    case (step)
      ST_RADIUS:  mul_b = cfg.tire_radius;
      ST_GEAR:    mul_b = cfg.gear_ratio;
      ST_CURRENT: mul_b = cfg.current_per_torque;
      ST_RESIST:  mul_b = cfg.phase_resistance;
      default:    mul_b = cfg.emf_coeff;
    endcase
  end

  // product shifted down by the fraction, saturating at 64 bits
  assign full = {prod_hi, 32'b0} + {32'b0, prod_lo};
  assign qres = (|full[95:64+FRAC_BITS]) ? '1 : full[63+FRAC_BITS:FRAC_BITS];

  // applied voltage magnitude from resistive part (rmag) and back emf (acc)
  always_comb begin
    if (item.fneg[wheel] == item.sneg[wheel]) begin
      app = (rmag > ~acc) ? '1 : rmag + acc;
    end else begin
      app = (rmag > acc) ? rmag - acc : acc - rmag;
    end
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_APP) ||
                     ((state == S_SLIP_DIV) && div_done && (wheel == 2'd3));
  assign div_num   = (state == S_APP) ? cfg.max_slip_voltage : item.supply;
  assign div_den   = (state == S_APP) ? rmag : vmax;

  whs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= ST_RADIUS;
      wheel     <= 2'd0;
    end else begin
      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item     <= q_data;
            acc      <= {32'b0, q_data.fmag[0]};
            wheel    <= 2'd0;
            step     <= ST_RADIUS;
            vmax     <= '0;
            slip_min <= SAT32;
            state    <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod_lo <= 64'(acc[31:0]) * 64'(mul_b);
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= 64'(acc[63:32]) * 64'(mul_b);
          state   <= S_MUL_SUM;
        end
        S_MUL_SUM: begin
          case (step)
            ST_RADIUS: begin
              acc   <= qres;
              step  <= ST_GEAR;
              state <= S_MUL_LO;
            end
            ST_GEAR: begin
              acc   <= qres;
              step  <= ST_CURRENT;
              state <= S_MUL_LO;
            end
            ST_CURRENT: begin
              acc   <= qres;
              step  <= ST_RESIST;
              state <= S_MUL_LO;
            end
            ST_RESIST: begin
              rmag  <= qres;
              acc   <= {16'b0, item.smag[wheel]};
              step  <= ST_EMF;
              state <= S_MUL_LO;
            end
            default: begin
              acc   <= qres;
              state <= S_APP;
            end
          endcase
        end
        S_APP: begin
          if (app > vmax) begin
            vmax <= app;
          end
          state <= S_SLIP_DIV;
        end
        S_SLIP_DIV: begin
          if (div_done) begin
            if (div_quot < slip_min) begin
              slip_min <= div_quot;
            end
            if (wheel == 2'd3) begin
              state <= S_RATIO_DIV;
            end else begin
              wheel <= wheel + 2'd1;
              acc   <= {32'b0, item.fmag[wheel + 2'd1]};
              step  <= ST_RADIUS;
              state <= S_MUL_LO;
            end
          end
        end
        S_RATIO_DIV: begin
          if (div_done) begin
            emf_ratio <= div_quot;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            if (emf_ratio > slip_min) begin
              scale_factor <= slip_min;
              slip_limited <= 1'b1;
            end else begin
              scale_factor <= emf_ratio;
              slip_limited <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider running while sequencer idle");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == S_SLIP_DIV) || (state == S_RATIO_DIV)))
    else $error("divider finished outside a divide wait");

  a_slip_not_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && slip_limited) |-> (scale_factor != SAT32))
    else $error("slip limited result at saturation");
`endif

endmodule

FILE: hw/rtl/wheel_torque_headroom_scaler.sv
// ----------------------------------------------------------------------------
// wheel_torque_headroom_scaler
// headroom scale factor for four wheel forces from supply and slip limits
// ----------------------------------------------------------------------------
// usage
//   input request: four forces, four motor speeds and the supply voltage,
//   taken when in_valid is high and in_stall is low
//   output request: scale_factor and slip_limited, taken when out_valid is
//   high and out_stall is low
//   config: cfg_index / cfg_data written when cfg_valid and cfg_ready are
//   high; cfg_ready is always high, unknown indexes are dropped
// timing
//   the front queue holds two requests, so requests are taken while the
//   back end works and while a result waits
//   the back end works on one request at a time; each request runs the
//   bit-serial divider once per wheel and once for the supply ratio, and
//   per wheel five 64x32 products on one 32x32 multiplier, each product
//   taken as a low half, a high half and then their sum
// reset
//   queue and output empty, all wheel constants set to 1.0 in Q16.16
// stall
//   a stalled result holds in the output register; the back end finishes
//   the next request and waits; the queue fills and then in_stall rises
// ----------------------------------------------------------------------------
module wheel_torque_headroom_scaler
  import whs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   force_0,
  input  logic signed [31:0]   force_1,
  input  logic signed [31:0]   force_2,
  input  logic signed [31:0]   force_3,
  input  logic signed [47:0]   motor_speed_0,
  input  logic signed [47:0]   motor_speed_1,
  input  logic signed [47:0]   motor_speed_2,
  input  logic signed [47:0]   motor_speed_3,
  input  logic        [31:0]   supply_voltage,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic        [31:0]   scale_factor,
  output logic                 slip_limited,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic        [31:0]   cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_data;
  logic  q_pop;

  // config register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tire_radius        <= CFG_RESET;
      cfg.gear_ratio         <= CFG_RESET;
      cfg.current_per_torque <= CFG_RESET;
      cfg.phase_resistance   <= CFG_RESET;
      cfg.emf_coeff          <= CFG_RESET;
      cfg.max_slip_voltage   <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIRE_RADIUS:        cfg.tire_radius        <= cfg_data;
        CFG_GEAR_RATIO:         cfg.gear_ratio         <= cfg_data;
        CFG_CURRENT_PER_TORQUE: cfg.current_per_torque <= cfg_data;
        CFG_PHASE_RESISTANCE:   cfg.phase_resistance   <= cfg_data;
        CFG_EMF_COEFF:          cfg.emf_coeff          <= cfg_data;
        CFG_MAX_SLIP_VOLTAGE:   cfg.max_slip_voltage   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and split into sign and magnitude
  whs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .force_0        (force_0),
    .force_1        (force_1),
    .force_2        (force_2),
    .force_3        (force_3),
    .motor_speed_0  (motor_speed_0),
    .motor_speed_1  (motor_speed_1),
    .motor_speed_2  (motor_speed_2),
    .motor_speed_3  (motor_speed_3),
    .supply_voltage (supply_voltage),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop)
  );

  // back: per-wheel products, divides and final min
  whs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scale_factor (scale_factor),
    .slip_limited (slip_limited)
  );

endmodule
